// ===== design/dnsw_pkg.sv =====
// shared widths, register indexes and bundle types for the day/night switch
// no dependencies; imported by every other file of the block except dnsw_out_if
package dnsw_pkg;

  localparam int LUM_W          = 16;
  localparam int TS_W           = 32;
  localparam int CONF_W         = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int SWITCH_HISTORY = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_D2N     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_N2D     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CONFIRM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOCKOUT = 3'd4;

  localparam logic [LUM_W-1:0]  D2N_RST     = 16'd30;
  localparam logic [LUM_W-1:0]  N2D_RST     = 16'd369;
  localparam logic [CONF_W-1:0] CONFIRM_RST = 8'd3;
  localparam logic [TS_W-1:0]   WINDOW_RST  = 32'd60000;
  localparam logic [TS_W-1:0]   LOCKOUT_RST = 32'd180000;

  typedef struct packed {
    logic [LUM_W-1:0]  day_to_night_level;
    logic [LUM_W-1:0]  night_to_day_level;
    logic [CONF_W-1:0] confirm_samples;
    logic [TS_W-1:0]   chatter_window_ms;
    logic [TS_W-1:0]   lockout_ms;
  } cfg_t;

  typedef struct packed {
    logic night;
    logic settled;
  } det_t;

  typedef struct packed {
    logic decided_night;
    logic applied_night;
    logic switched;
    logic switch_held;
    logic lockout_active;
    logic slow_sampling;
  } res_t;

endpackage

// ===== design/dnsw_in_if.sv =====
// input channel: luminance sample with millisecond timestamp
// depends on dnsw_pkg
interface dnsw_in_if import dnsw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LUM_W-1:0] luminance;
  logic [TS_W-1:0]  now_ms;

  modport source (output valid, output luminance, output now_ms, input ready);
  modport sink (input valid, input luminance, input now_ms, output ready);
endinterface

// ===== design/dnsw_out_if.sv =====
// result channel: decision, applied mode and lockout status
// no dependencies
interface dnsw_out_if;
  logic valid;
  logic ready;
  logic decided_night;
  logic applied_night;
  logic switched;
  logic switch_held;
  logic lockout_active;
  logic slow_sampling;

  modport source (output valid, output decided_night, output applied_night,
                  output switched, output switch_held, output lockout_active,
                  output slow_sampling, input ready);
  modport sink (input valid, input decided_night, input applied_night,
                input switched, input switch_held, input lockout_active,
                input slow_sampling, output ready);
endinterface

// ===== design/dnsw_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on dnsw_pkg
interface dnsw_cfg_if import dnsw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/dnsw_cfg_regs.sv =====
// configuration register file for the day/night switch
// depends on dnsw_pkg
module dnsw_cfg_regs import dnsw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_IDX_D2N:     cfg_nxt.day_to_night_level = wr_data[LUM_W-1:0];
        CFG_IDX_N2D:     cfg_nxt.night_to_day_level = wr_data[LUM_W-1:0];
        CFG_IDX_CONFIRM: cfg_nxt.confirm_samples    = wr_data[CONF_W-1:0];
        CFG_IDX_WINDOW:  cfg_nxt.chatter_window_ms  = wr_data[TS_W-1:0];
        CFG_IDX_LOCKOUT: cfg_nxt.lockout_ms         = wr_data[TS_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.day_to_night_level <= D2N_RST;
      cfg_r.night_to_day_level <= N2D_RST;
      cfg_r.confirm_samples    <= CONFIRM_RST;
      cfg_r.chatter_window_ms  <= WINDOW_RST;
      cfg_r.lockout_ms         <= LOCKOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/dnsw_detect.sv =====
// hysteresis detector with saturating confirmation run counters
// depends on dnsw_pkg
module dnsw_detect import dnsw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [LUM_W-1:0] luminance,
  input  cfg_t             cfg,
  output det_t             det_nxt
);

  logic              night_r, night_nxt;
  logic              settled_r, settled_nxt;
  logic [CONF_W-1:0] bright_r, bright_nxt;
  logic [CONF_W-1:0] dark_r, dark_nxt;
  logic [CONF_W-1:0] bright_inc, dark_inc;

  assign bright_inc = (&bright_r) ? bright_r : bright_r + CONF_W'(1);
  assign dark_inc   = (&dark_r) ? dark_r : dark_r + CONF_W'(1);

  always_comb begin
    night_nxt   = night_r;
    settled_nxt = settled_r;
    bright_nxt  = bright_r;
    dark_nxt    = dark_r;
    if (!night_r) begin
      if (luminance < cfg.day_to_night_level) begin
        bright_nxt = '0;
        dark_nxt   = dark_inc;
        if (dark_inc >= cfg.confirm_samples) begin
          night_nxt   = 1'b1;
          settled_nxt = 1'b1;
        end
      end else begin
        dark_nxt   = '0;
        bright_nxt = bright_inc;
        if (bright_inc >= cfg.confirm_samples) begin
          settled_nxt = 1'b1;
        end
      end
    end else if (luminance > cfg.night_to_day_level) begin
      dark_nxt   = '0;
      bright_nxt = bright_inc;
      if (bright_inc >= cfg.confirm_samples) begin
        night_nxt   = 1'b0;
        settled_nxt = 1'b1;
      end
    end else begin
      bright_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      night_r   <= 1'b0;
      settled_r <= 1'b0;
      bright_r  <= '0;
      dark_r    <= '0;
    end else if (step) begin
      night_r   <= night_nxt;
      settled_r <= settled_nxt;
      bright_r  <= bright_nxt;
      dark_r    <= dark_nxt;
    end
  end

  assign det_nxt.night   = night_nxt;
  assign det_nxt.settled = settled_nxt;

endmodule

// ===== design/dnsw_lockout.sv =====
// applied mode, switch time history and chatter lockout
// depends on dnsw_pkg
module dnsw_lockout import dnsw_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [TS_W-1:0] now_ms,
  input  logic            decided_night,
  input  cfg_t            cfg,
  output logic            applied_nxt,
  output logic            switched,
  output logic            held,
  output logic            lock_nxt
);

  logic            applied_r;
  logic            lock_r;
  logic [TS_W-1:0] begin_r, begin_nxt;
  logic [TS_W-1:0] times_r   [SWITCH_HISTORY];
  logic [TS_W-1:0] times_nxt [SWITCH_HISTORY];
  logic [TS_W-1:0] since_lock, since_oldest, oldest;
  logic            release_lock, lock_eff;

  assign since_lock   = now_ms - begin_r;
  assign release_lock = lock_r && (since_lock >= cfg.lockout_ms);
  assign lock_eff     = lock_r && !release_lock;
  // entry that becomes oldest after the shift, empty if the history was just cleared
  assign oldest       = release_lock ? '0 : times_r[SWITCH_HISTORY-2];
  assign since_oldest = now_ms - oldest;

  always_comb begin
    applied_nxt = applied_r;
    switched    = 1'b0;
    held        = 1'b0;
    lock_nxt    = lock_eff;
    begin_nxt   = release_lock ? '0 : begin_r;
    for (int i = 0; i < SWITCH_HISTORY; i++) begin
      times_nxt[i] = release_lock ? '0 : times_r[i];
    end
    if (applied_r != decided_night) begin
      if (lock_eff) begin
        held = 1'b1;
      end else begin
        for (int i = 1; i < SWITCH_HISTORY; i++) begin
          times_nxt[i] = release_lock ? '0 : times_r[i-1];
        end
        times_nxt[0] = now_ms;
        if ((oldest != '0) && (since_oldest < cfg.chatter_window_ms)) begin
          lock_nxt  = 1'b1;
          begin_nxt = now_ms;
        end
        applied_nxt = decided_night;
        switched    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      applied_r <= 1'b0;
      lock_r    <= 1'b0;
      begin_r   <= '0;
      for (int i = 0; i < SWITCH_HISTORY; i++) begin
        times_r[i] <= '0;
      end
    end else if (step) begin
      applied_r <= applied_nxt;
      lock_r    <= lock_nxt;
      begin_r   <= begin_nxt;
      for (int i = 0; i < SWITCH_HISTORY; i++) begin
        times_r[i] <= times_nxt[i];
      end
    end
  end

endmodule

// ===== design/day_night_switch_with_chatter_lockout_unit.sv =====
// day/night switch with chatter lockout, top level
// path: an input transaction passes the input register, then the result register, to result valid
// throughput: one transaction per cycle while results are taken; detector and lockout update are combinational
// input and result registers stall together when the result is not taken
// reset: day mode decided and applied, run counters zero, history empty, registers at defaults
module day_night_switch_with_chatter_lockout_unit import dnsw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dnsw_in_if.sink     in_ch,
  dnsw_out_if.source  out_ch,
  dnsw_cfg_if.sink    cfg_ch
);

  cfg_t             cfg;
  det_t             det_nxt;
  logic             in_vld_r;
  logic [LUM_W-1:0] lum_r;
  logic [TS_W-1:0]  now_r;
  logic             out_vld_r;
  res_t             res_r, res_nxt;
  logic             step, out_free;
  logic             applied_nxt, switched, held, lock_nxt;

  assign cfg_ch.ready = 1'b1;

  dnsw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  assign out_free    = !out_vld_r || out_ch.ready;
  assign step        = in_vld_r && out_free;
  assign in_ch.ready = !in_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      lum_r <= in_ch.luminance;
      now_r <= in_ch.now_ms;
    end
  end

  dnsw_detect u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .luminance (lum_r),
    .cfg       (cfg),
    .det_nxt   (det_nxt)
  );

  dnsw_lockout u_lockout (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .now_ms        (now_r),
    .decided_night (det_nxt.night),
    .cfg           (cfg),
    .applied_nxt   (applied_nxt),
    .switched      (switched),
    .held          (held),
    .lock_nxt      (lock_nxt)
  );

  always_comb begin
    res_nxt.decided_night  = det_nxt.night;
    res_nxt.applied_night  = applied_nxt;
    res_nxt.switched       = switched;
    res_nxt.switch_held    = held;
    res_nxt.lockout_active = lock_nxt;
    res_nxt.slow_sampling  = det_nxt.settled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.decided_night  = res_r.decided_night;
  assign out_ch.applied_night  = res_r.applied_night;
  assign out_ch.switched       = res_r.switched;
  assign out_ch.switch_held    = res_r.switch_held;
  assign out_ch.lockout_active = res_r.lockout_active;
  assign out_ch.slow_sampling  = res_r.slow_sampling;

  a_switch_not_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.switched) |-> !res_r.switch_held)
    else $error("switch and hold reported together");

  a_held_in_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.switch_held) |->
      (res_r.lockout_active && (res_r.applied_night != res_r.decided_night)))
    else $error("hold reported outside lockout or without pending change");

  a_switch_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.switched) |-> (res_r.applied_night == res_r.decided_night))
    else $error("switched result does not follow the decision");

  a_result_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(step))
    else $error("result appeared without a processed transaction");

endmodule

// ===== bench/tb_day_night_switch_with_chatter_lockout_unit.sv =====
`timescale 1ns / 100ps
// testbench for the day/night switch with chatter lockout: directed and random samples,
// per-transaction prediction of mode, switch and lockout status across several register sets
// depends on dnsw_pkg, the dnsw_*_if interfaces and day_night_switch_with_chatter_lockout_unit
module tb_day_night_switch_with_chatter_lockout_unit;
  import dnsw_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [LUM_W-1:0] lum;
    logic [TS_W-1:0]  stamp;
  } sample_t;

  logic clk;
  logic rst_n;

  dnsw_in_if  in_ch ();
  dnsw_out_if out_ch ();
  dnsw_cfg_if cfg_ch ();

  day_night_switch_with_chatter_lockout_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sample_t samples_to_send[$];
  res_t    mode_results_due[$];
  sample_t next_sample;
  res_t    want_result;
  int      unsent_samples;
  int      failures;
  int      cycle_count;
  int      send_idle_pct;
  int      recv_stall_pct;
  logic    sender_hold;
  logic [TS_W-1:0] stamp_clock;

  // shadow of the block's registers and state
  cfg_t            shadow_cfg;
  logic            night_dec;
  logic [7:0]      bright_cnt;
  logic [7:0]      dark_cnt;
  logic            is_settled;
  logic            applied_night_m;
  logic            lock_on;
  logic [TS_W-1:0] lock_start;
  logic [TS_W-1:0] toggle_hist [SWITCH_HISTORY];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(input string field, input logic got, input logic want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %b expected %b", field, got, want));
    end
  endtask

  function automatic void clear_lock_history();
    int i;
    lock_on    = 1'b0;
    lock_start = '0;
    for (i = 0; i < SWITCH_HISTORY; i++) begin
      toggle_hist[i] = '0;
    end
  endfunction

  function automatic res_t predict_mode_update(input logic [LUM_W-1:0] lum,
                                               input logic [TS_W-1:0] now);
    res_t            r;
    logic [TS_W-1:0] oldest;
    logic [TS_W-1:0] elapsed;
    int              i;
    r = '0;
    if (!night_dec) begin
      if (lum < shadow_cfg.day_to_night_level) begin
        bright_cnt = '0;
        if (dark_cnt != 8'hFF) dark_cnt = dark_cnt + 8'd1;
        if (dark_cnt >= shadow_cfg.confirm_samples) begin
          night_dec  = 1'b1;
          is_settled = 1'b1;
        end
      end else begin
        dark_cnt = '0;
        if (bright_cnt != 8'hFF) bright_cnt = bright_cnt + 8'd1;
        if (bright_cnt >= shadow_cfg.confirm_samples) is_settled = 1'b1;
      end
    end else if (lum > shadow_cfg.night_to_day_level) begin
      dark_cnt = '0;
      if (bright_cnt != 8'hFF) bright_cnt = bright_cnt + 8'd1;
      if (bright_cnt >= shadow_cfg.confirm_samples) begin
        night_dec  = 1'b0;
        is_settled = 1'b1;
      end
    end else begin
      bright_cnt = '0;
    end

    elapsed = now - lock_start;
    if (lock_on && elapsed >= shadow_cfg.lockout_ms) clear_lock_history();

    if (applied_night_m != night_dec) begin
      if (lock_on) begin
        r.switch_held = 1'b1;
      end else begin
        for (i = SWITCH_HISTORY - 1; i > 0; i--) begin
          toggle_hist[i] = toggle_hist[i-1];
        end
        toggle_hist[0] = now;
        oldest  = toggle_hist[SWITCH_HISTORY-1];
        elapsed = now - oldest;
        if (oldest != '0 && elapsed < shadow_cfg.chatter_window_ms) begin
          lock_on    = 1'b1;
          lock_start = now;
        end
        applied_night_m = night_dec;
        r.switched      = 1'b1;
      end
    end

    r.decided_night  = night_dec;
    r.applied_night  = applied_night_m;
    r.lockout_active = lock_on;
    r.slow_sampling  = is_settled;
    return r;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        mode_results_due.push_back(predict_mode_update(in_ch.luminance, in_ch.now_ms));
        unsent_samples--;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (samples_to_send.size() != 0 && !sender_hold &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          next_sample = samples_to_send.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.luminance <= next_sample.lum;
          in_ch.now_ms    <= next_sample.stamp;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (mode_results_due.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want_result = mode_results_due.pop_front();
          check_field("decided_night", out_ch.decided_night, want_result.decided_night);
          check_field("applied_night", out_ch.applied_night, want_result.applied_night);
          check_field("switched", out_ch.switched, want_result.switched);
          check_field("switch_held", out_ch.switch_held, want_result.switch_held);
          check_field("lockout_active", out_ch.lockout_active, want_result.lockout_active);
          check_field("slow_sampling", out_ch.slow_sampling, want_result.slow_sampling);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic queue_sample(input logic [LUM_W-1:0] lum, input logic [TS_W-1:0] stamp);
    sample_t s;
    s.lum   = lum;
    s.stamp = stamp;
    samples_to_send.push_back(s);
    unsent_samples++;
  endtask

  task automatic wait_until_drained();
    do @(posedge clk); while (unsent_samples != 0 || mode_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_IDX_D2N:     shadow_cfg.day_to_night_level = val[LUM_W-1:0];
      CFG_IDX_N2D:     shadow_cfg.night_to_day_level = val[LUM_W-1:0];
      CFG_IDX_CONFIRM: shadow_cfg.confirm_samples    = val[CONF_W-1:0];
      CFG_IDX_WINDOW:  shadow_cfg.chatter_window_ms  = val[TS_W-1:0];
      CFG_IDX_LOCKOUT: shadow_cfg.lockout_ms         = val[TS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [TS_W-1:0] advance_stamp(input int unsigned step_max);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) stamp_clock = '0;
    else if (pick < 4) stamp_clock = 32'hFFFF_FFFF - $urandom_range(0, step_max);
    else if (pick < 7) stamp_clock = $urandom;
    else stamp_clock = stamp_clock + $urandom_range(0, step_max);
    return stamp_clock;
  endfunction

  function automatic logic [LUM_W-1:0] pick_luminance(input int unsigned kind);
    int unsigned d2n;
    int unsigned n2d;
    logic [31:0] raw;
    d2n = shadow_cfg.day_to_night_level;
    n2d = shadow_cfg.night_to_day_level;
    raw = $urandom;
    if (kind < 35) begin
      if (d2n != 0) raw = $urandom_range(0, d2n - 1);
    end else if (kind < 70) begin
      if (n2d != 65535) raw = $urandom_range(n2d + 1, 65535);
    end else if (kind < 85) begin
      if (d2n <= n2d) raw = $urandom_range(d2n, n2d);
    end
    return raw[LUM_W-1:0];
  endfunction

  // bursts of dark, bright or in-between samples, plus some noise
  task automatic queue_random_samples(input int count, input int unsigned step_max);
    int          n;
    int          k;
    int unsigned kind;
    int unsigned burst;
    int unsigned confirm;
    n = 0;
    while (n < count) begin
      kind    = $urandom_range(0, 99);
      confirm = shadow_cfg.confirm_samples;
      burst   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300)
                                            : $urandom_range(1, confirm + 2);
      for (k = 0; k < burst && n < count; k++) begin
        queue_sample(pick_luminance(kind), advance_stamp(step_max));
        n++;
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] d2n, input logic [CFG_DATA_W-1:0] n2d,
                           input logic [CFG_DATA_W-1:0] confirm,
                           input logic [CFG_DATA_W-1:0] window,
                           input logic [CFG_DATA_W-1:0] lockout,
                           input int idle_pct, input int stall_pct,
                           input int count, input int unsigned step_max);
    wait_until_drained();
    write_register(CFG_IDX_D2N, d2n);
    write_register(CFG_IDX_N2D, n2d);
    write_register(CFG_IDX_CONFIRM, confirm);
    write_register(CFG_IDX_WINDOW, window);
    write_register(CFG_IDX_LOCKOUT, lockout);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random_samples(count, step_max);
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.luminance = '0;
    in_ch.now_ms    = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_IDX_D2N;
    cfg_ch.data     = '0;
    unsent_samples  = 0;
    failures        = 0;
    cycle_count     = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    sender_hold     = 1'b0;
    stamp_clock     = '0;

    shadow_cfg.day_to_night_level = D2N_RST;
    shadow_cfg.night_to_day_level = N2D_RST;
    shadow_cfg.confirm_samples    = CONFIRM_RST;
    shadow_cfg.chatter_window_ms  = WINDOW_RST;
    shadow_cfg.lockout_ms         = LOCKOUT_RST;
    night_dec       = 1'b0;
    bright_cnt      = '0;
    dark_cnt        = '0;
    is_settled      = 1'b0;
    applied_night_m = 1'b0;
    clear_lock_history();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset levels: switch at time zero, threshold edges, lockout on the sixth switch, released at the last sample
    queue_sample(16'hFFFF, 32'd0);
    queue_sample(16'd0, 32'd0);
    queue_sample(16'd0, 32'd0);
    queue_sample(16'd0, 32'd0);
    queue_sample(16'd369, 32'd100);
    queue_sample(16'd370, 32'd200);
    queue_sample(16'hFFFF, 32'd300);
    queue_sample(16'd400, 32'd400);
    queue_sample(16'd29, 32'd500);
    queue_sample(16'd0, 32'd600);
    queue_sample(16'd1, 32'd700);
    queue_sample(16'd30, 32'd800);
    queue_sample(16'd370, 32'd900);
    queue_sample(16'd370, 32'd1000);
    queue_sample(16'd370, 32'd1100);
    queue_sample(16'd0, 32'd1200);
    queue_sample(16'd0, 32'd1300);
    queue_sample(16'd0, 32'd1400);
    queue_sample(16'hFFFF, 32'd1500);
    queue_sample(16'hFFFF, 32'd1600);
    queue_sample(16'hFFFF, 32'd1700);
    queue_sample(16'd0, 32'd1800);
    queue_sample(16'd0, 32'd1900);
    queue_sample(16'd0, 32'd2000);
    queue_sample(16'd0, 32'd181700);

    run_phase(32'd1000, 32'd3000, 32'd1, 32'd20000, 32'd5000, 0, 0, 300, 1000);
    run_phase(32'd65535, 32'd0, 32'd2, 32'hFFFF_FFFF, 32'd0, 74, 0, 250, 100);
    run_phase(32'd0, 32'd65535, 32'd255, 32'd0, 32'hFFFF_FFFF, 0, 74, 100, 1000);
    run_phase(32'd20000, 32'd20000, 32'd255, 32'd100000, 32'd50000, 0, 74, 250, 50);
    run_phase(32'd30, 32'd369, 32'd3, 32'd60000, 32'd180000, 20, 20, 300, 2000);

    // hold the sender until the block has returned everything
    do @(posedge clk); while (unsent_samples > 150);
    sender_hold = 1'b1;
    do @(posedge clk); while (mode_results_due.size() != 0 || in_ch.valid);
    sender_hold = 1'b0;

    run_phase(32'd40000, 32'd10000, 32'd0, 32'd4000, 32'd1, 20, 20, 150, 300);

    wait_until_drained();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dnsw_pkg.sv
design/dnsw_in_if.sv
design/dnsw_out_if.sv
design/dnsw_cfg_if.sv
design/dnsw_cfg_regs.sv
design/dnsw_detect.sv
design/dnsw_lockout.sv
design/day_night_switch_with_chatter_lockout_unit.sv
bench/tb_day_night_switch_with_chatter_lockout_unit.sv
